// ===== src/xh32_pkg.sv =====
// xh32_pkg: shared constants and types for the xxHash32 byte stream core.
// No dependencies; imported by xh32_front, xh32_back and the top level.
`default_nettype none

package xh32_pkg;

  localparam logic [31:0] PRIME1 = 32'h9E37_79B1;
  localparam logic [31:0] PRIME2 = 32'h85EB_CA77;
  localparam logic [31:0] PRIME3 = 32'hC2B2_AE3D;
  localparam logic [31:0] PRIME4 = 32'h27D4_EB2F;
  localparam logic [31:0] PRIME5 = 32'h1656_67B1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] REG_IDX_SEED = 3'd0;

  // one classified beat handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } xh_item_t;

endpackage

`default_nettype wire

// ===== src/xxhash32_byte_stream_core.sv =====
// xxhash32_byte_stream_core: top level of the xxHash32-style byte stream hasher.
// Depends on xh32_pkg, xh32_front and xh32_back.
//
// Usage:
//  - in_ beats carry one message byte in in_tdata; in_tuser says the byte is
//    present, in_tlast ends the message. A beat with neither is dropped.
//  - out_ beats carry the 32-bit digest, one per message, after its last beat.
//  - cfg_ is an APB write/read port; the seed register sits at address 0 and
//    is to be written only between messages; the block itself does not enforce this.
// Throughput: the back end takes one byte per cycle while idle; it takes none
//  while it folds a completed 16-byte stripe (four lanes in turn, on the one shared
//  multiplier) or forms a digest. A four-entry queue in front absorbs bytes while it folds.
// Digest steps after the last beat is taken by the back end: the stripe fold if
//  that byte completes a stripe, FIN0 and FIN1, one word step per whole word and one
//  byte step per byte left of the message tail (0..15 bytes), then the avalanche steps.
// The digest waits in an output register; the back end carries on with the
//  next message and only holds at the end of it if that register is still
//  full. in_tready drops when the queue is full.
// Reset clears the queue, the byte count and the seed (to zero) and loads
//  the lane starts for that seed; no clearing pass is needed.
`default_nettype none

module xxhash32_byte_stream_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] byte_valid
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import xh32_pkg::*;

  logic [31:0] seed_r;
  logic        seed_wr;
  logic        item_valid;
  logic        item_pop;
  xh_item_t    item;

  assign cfg_pready = 1'b1;
  assign seed_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && ({cfg_paddr[2], 2'b00} == REG_IDX_SEED);
  assign cfg_prdata = ({cfg_paddr[2], 2'b00} == REG_IDX_SEED) ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (seed_wr) begin
      seed_r <= cfg_pwdata;
    end
  end

  xh32_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  xh32_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .seed       (seed_wr ? cfg_pwdata : seed_r),
    .seed_load  (seed_wr),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== src/xh32_front.sv =====
// xh32_front: accepts input beats, drops empty ones, queues the rest.
// Depends on xh32_pkg for the queue item type and depth.
`default_nettype none

module xh32_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,
  input  wire logic              in_tuser,
  input  wire logic              in_tlast,
  output logic                   item_valid,
  output xh32_pkg::xh_item_t     item,
  input  wire logic              item_pop
);
  import xh32_pkg::*;

  xh_item_t            q_r [QUEUE_DEPTH];
  logic [QPTR_W:0]     wp_r, wp_nxt;
  logic [QPTR_W:0]     rp_r, rp_nxt;
  logic [QPTR_W:0]     fill;
  logic                push;

  assign fill       = wp_r - rp_r;
  assign in_tready  = (fill != QUEUE_DEPTH[QPTR_W:0]);
  assign push       = in_tvalid && in_tready && (in_tuser || in_tlast);
  assign item_valid = (fill != '0);
  assign item       = q_r[rp_r[QPTR_W-1:0]];

  always_comb begin
    wp_nxt = push ? wp_r + 1'b1 : wp_r;
    rp_nxt = (item_pop && item_valid) ? rp_r + 1'b1 : rp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r[QPTR_W-1:0]] <= '{data_byte: in_tdata, has_byte: in_tuser, is_last: in_tlast};
    end
  end

endmodule

`default_nettype wire

// ===== src/xh32_back.sv =====
// xh32_back: sequencer that buffers stripes, folds lanes and forms the digest
// with one shared registered 32x32 multiplier. Depends on xh32_pkg.
`default_nettype none

module xh32_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [31:0]        seed,
  input  wire logic               seed_load,
  input  wire logic               item_valid,
  input  wire xh32_pkg::xh_item_t item,
  output logic                    item_pop,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [31:0]             out_tdata
);
  import xh32_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_F_MUL1 = 5'd1;
  localparam logic [4:0] S_F_ROT  = 5'd2;
  localparam logic [4:0] S_F_MUL2 = 5'd3;
  localparam logic [4:0] S_F_WR   = 5'd4;
  localparam logic [4:0] S_FIN0   = 5'd5;
  localparam logic [4:0] S_FIN1   = 5'd6;
  localparam logic [4:0] S_TAIL   = 5'd7;
  localparam logic [4:0] S_TW_ROT = 5'd8;
  localparam logic [4:0] S_TW_MUL = 5'd9;
  localparam logic [4:0] S_TW_WR  = 5'd10;
  localparam logic [4:0] S_TB_ROT = 5'd11;
  localparam logic [4:0] S_TB_MUL = 5'd12;
  localparam logic [4:0] S_TB_WR  = 5'd13;
  localparam logic [4:0] S_AV0    = 5'd14;
  localparam logic [4:0] S_AV1    = 5'd15;
  localparam logic [4:0] S_AV2    = 5'd16;
  localparam logic [4:0] S_AV3    = 5'd17;
  localparam logic [4:0] S_AV4    = 5'd18;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] k);
    rotl32 = (v << k) | (v >> (6'd32 - {1'b0, k}));
  endfunction

  logic [4:0]  state_r, state_nxt;
  logic [31:0] lane_r [4];
  logic [31:0] wbuf_r [4];
  logic [31:0] cnt_r;
  logic        done_r;
  logic        pend_last_r;
  logic [1:0]  k_r;
  logic [3:0]  pos_r;
  logic [31:0] h_r;
  logic [31:0] t_r;
  logic [31:0] mul_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic [31:0] mul_a, mul_b;
  logic        mul_en;
  logic [1:0]  rd_idx;
  logic [31:0] word_rd;
  logic [7:0]  byte_rd;
  logic [3:0]  rem;
  logic        word_left, byte_left;
  logic        out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign rem       = cnt_r[3:0];
  assign word_left = ({1'b0, pos_r} + 5'd4) <= {1'b0, rem};
  assign byte_left = pos_r < rem;
  assign rd_idx    = (state_r == S_F_MUL1) ? k_r : pos_r[3:2];
  assign word_rd   = wbuf_r[rd_idx];
  assign byte_rd   = word_rd[{pos_r[1:0], 3'b000} +: 8];
  assign out_free  = !out_valid_r || out_tready;
  assign item_pop  = (state_r == S_IDLE) && item_valid;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = t_r;
    mul_b  = PRIME1;
    case (state_r)
      S_F_MUL1: begin
        mul_a = word_rd;
        mul_b = PRIME2;
      end
      S_F_MUL2: mul_b = PRIME1;
      S_TAIL: begin
        mul_a = word_left ? word_rd : {24'd0, byte_rd};
        mul_b = word_left ? PRIME3 : PRIME5;
      end
      S_TW_MUL: mul_b = PRIME4;
      S_TB_MUL: mul_b = PRIME1;
      S_AV1:    mul_b = PRIME2;
      S_AV3:    mul_b = PRIME3;
      default:  mul_en = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          if (item.has_byte && (cnt_r[3:0] == 4'hF)) begin
            state_nxt = S_F_MUL1;
          end else if (item.is_last) begin
            state_nxt = S_FIN0;
          end
        end
      end
      S_F_MUL1: state_nxt = S_F_ROT;
      S_F_ROT:  state_nxt = S_F_MUL2;
      S_F_MUL2: state_nxt = S_F_WR;
      S_F_WR: begin
        if (k_r != 2'd3) begin
          state_nxt = S_F_MUL1;
        end else begin
          state_nxt = pend_last_r ? S_FIN0 : S_IDLE;
        end
      end
      S_FIN0: state_nxt = S_FIN1;
      S_FIN1: state_nxt = S_TAIL;
      S_TAIL: begin
        if (word_left) begin
          state_nxt = S_TW_ROT;
        end else if (byte_left) begin
          state_nxt = S_TB_ROT;
        end else begin
          state_nxt = S_AV0;
        end
      end
      S_TW_ROT: state_nxt = S_TW_MUL;
      S_TW_MUL: state_nxt = S_TW_WR;
      S_TW_WR:  state_nxt = S_TAIL;
      S_TB_ROT: state_nxt = S_TB_MUL;
      S_TB_MUL: state_nxt = S_TB_WR;
      S_TB_WR:  state_nxt = S_TAIL;
      S_AV0:    state_nxt = S_AV1;
      S_AV1:    state_nxt = S_AV2;
      S_AV2:    state_nxt = S_AV3;
      S_AV3:    state_nxt = S_AV4;
      S_AV4: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      pend_last_r <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      lane_r[0]   <= PRIME1 + PRIME2;
      lane_r[1]   <= PRIME2;
      lane_r[2]   <= '0;
      lane_r[3]   <= PRIME1;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_AV4) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          // lanes follow the seed only until the first stripe is folded
          if (seed_load && !done_r) begin
            lane_r[0] <= seed + PRIME1 + PRIME2;
            lane_r[1] <= seed + PRIME2;
            lane_r[2] <= seed;
            lane_r[3] <= seed + PRIME1;
          end
          if (item_valid) begin
            pend_last_r <= item.is_last;
            k_r         <= '0;
            if (item.has_byte) begin
              cnt_r <= cnt_r + 32'd1;
            end
          end
        end
        S_F_WR: begin
          lane_r[k_r] <= mul_r;
          done_r      <= 1'b1;
          k_r         <= k_r + 2'd1;
        end
        S_AV4: begin
          if (out_free) begin
            cnt_r      <= '0;
            done_r     <= 1'b0;
            lane_r[0]  <= seed + PRIME1 + PRIME2;
            lane_r[1]  <= seed + PRIME2;
            lane_r[2]  <= seed;
            lane_r[3]  <= seed + PRIME1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mul_r <= mul_a * mul_b;
    end
    if (item_pop && item.has_byte) begin
      wbuf_r[cnt_r[3:2]][{cnt_r[1:0], 3'b000} +: 8] <= item.data_byte;
    end
    case (state_r)
      S_F_ROT: t_r <= rotl32(lane_r[k_r] + mul_r, 5'd13);
      S_FIN0: begin
        if (done_r) begin
          h_r <= rotl32(lane_r[0], 5'd1) + rotl32(lane_r[1], 5'd7);
          t_r <= rotl32(lane_r[2], 5'd12) + rotl32(lane_r[3], 5'd18);
        end else begin
          h_r <= seed + PRIME5;
          t_r <= '0;
        end
      end
      S_FIN1: begin
        h_r   <= h_r + t_r + cnt_r;
        pos_r <= '0;
      end
      S_TW_ROT: t_r <= rotl32(h_r + mul_r, 5'd17);
      S_TW_WR: begin
        h_r   <= mul_r;
        pos_r <= pos_r + 4'd4;
      end
      S_TB_ROT: t_r <= rotl32(h_r + mul_r, 5'd11);
      S_TB_WR: begin
        h_r   <= mul_r;
        pos_r <= pos_r + 4'd1;
      end
      S_AV0: t_r <= h_r ^ (h_r >> 15);
      S_AV2: t_r <= mul_r ^ (mul_r >> 13);
      S_AV4: begin
        if (out_free) begin
          out_data_r <= mul_r ^ (mul_r >> 16);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/xxhash32_byte_stream_core_tb.sv =====
// Self-checking testbench for xxhash32_byte_stream_core: directed and random byte messages.
// A scoreboard class predicts each digest from the accepted in_ beats and checks out_ beats.
// Depends on xh32_pkg and the core RTL only.
`default_nettype none

module xxhash32_byte_stream_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xh32_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned PHASE_BEATS = 230;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned SQUEEZE_CYCLES = 400;
  localparam logic [2:0] SEED_ADDR = 3'(4 * REG_IDX_SEED);

  class xh32_scoreboard;
    logic [31:0] seed;
    logic [31:0] lanes[4];
    logic [7:0]  stripe[16];
    logic [31:0] nbytes;
    bit          folded;
    logic [31:0] digest_q[$];
    int          errors;

    function new();
      seed = '0;
      nbytes = '0;
      folded = 1'b0;
      errors = 0;
    endfunction

    function automatic logic [31:0] rotl(logic [31:0] v, int unsigned k);
      return (v << k) | (v >> (32 - k));
    endfunction

    function automatic logic [31:0] word_at(int unsigned p);
      return {stripe[p + 3], stripe[p + 2], stripe[p + 1], stripe[p]};
    endfunction

    // accepted in_ beat: update the running state, queue a digest on the last beat
    function void note_beat(xh_item_t it);
      logic [31:0] h;
      int unsigned rem;
      int unsigned pos;
      if (it.has_byte) begin
        stripe[nbytes[3:0]] = it.data_byte;
        nbytes++;
        if (nbytes[3:0] == 4'd0) begin
          if (!folded) begin
            lanes[0] = seed + PRIME1 + PRIME2;
            lanes[1] = seed + PRIME2;
            lanes[2] = seed;
            lanes[3] = seed + PRIME1;
          end
          for (int k = 0; k < 4; k++)
            lanes[k] = rotl(lanes[k] + word_at(4 * k) * PRIME2, 13) * PRIME1;
          folded = 1'b1;
        end
      end
      if (!it.is_last) return;
      if (folded)
        h = rotl(lanes[0], 1) + rotl(lanes[1], 7) + rotl(lanes[2], 12) + rotl(lanes[3], 18);
      else
        h = seed + PRIME5;
      h += nbytes;
      rem = 32'(nbytes[3:0]);
      pos = 0;
      while (pos + 4 <= rem) begin
        h = rotl(h + word_at(pos) * PRIME3, 17) * PRIME4;
        pos += 4;
      end
      while (pos < rem) begin
        h = rotl(h + {24'h0, stripe[pos]} * PRIME5, 11) * PRIME1;
        pos++;
      end
      h ^= h >> 15;
      h *= PRIME2;
      h ^= h >> 13;
      h *= PRIME3;
      h ^= h >> 16;
      digest_q.push_back(h);
      nbytes = '0;
      folded = 1'b0;
    endfunction

    function void check_digest(logic [31:0] actual);
      logic [31:0] exp_d;
      if (digest_q.size() == 0) begin
        $error("digest: unexpected beat, actual %h", actual);
        errors++;
        return;
      end
      exp_d = digest_q.pop_front();
      if (actual !== exp_d) begin
        $error("digest: expected %h, actual %h", exp_d, actual);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] data_byte
  logic        in_tuser = 1'b0;  // [0] byte_valid
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [31:0] digest
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  xh32_scoreboard sb = new();
  int unsigned beats_sent = 0;
  bit no_gaps = 1'b0;
  bit squeeze = 1'b0;

  xxhash32_byte_stream_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // mostly none, sometimes short, rarely long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic has_b, input logic lst);
    int unsigned gap;
    xh_item_t it;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= has_b;
    in_tlast <= lst;
    // in_tready is settled mid-cycle, ahead of the accepting edge
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    it = '{data_byte: b, has_byte: has_b, is_last: lst};
    sb.note_beat(it);
    if (has_b || lst) beats_sent++;
  endtask

  // message of len bytes; either the last byte carries tlast or a byteless end beat follows
  task automatic send_message(input int unsigned len, input bit tail_byte);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 4) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(pick_byte(), 1'b1, tail_byte && (i == len - 1));
    end
    if (!tail_byte || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic write_seed(input logic [31:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= SEED_ADDR;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.seed = v;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic settle();
    while (sb.digest_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random back-pressure plus one long hold-off
  initial begin
    int unsigned stall_left;
    bit squeezed;
    bit took;
    logic [31:0] got;
    stall_left = 0;
    squeezed = 1'b0;
    forever begin
      @(negedge clk);
      took = rst_n && out_tvalid && out_tready;
      got = out_tdata;
      @(posedge clk);
      if (took) sb.check_digest(got);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        stall_left = SQUEEZE_CYCLES;
      end
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [31:0] seeds[5];
    int unsigned sent0;
    int unsigned r;
    int unsigned len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty message, dropped beat, one byte, word plus byte tail, exact stripe
    send_beat(8'hA5, 1'b0, 1'b1);
    send_beat(8'h3C, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h80, 1'b1, 1'b0);
    send_beat(8'h01, 1'b1, 1'b0);
    send_beat(8'h7F, 1'b1, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b1);
    for (int i = 0; i < 16; i++)
      send_beat((i % 2) ? 8'hFF : 8'(i * 17), 1'b1, i == 15);
    in_tvalid <= 1'b0;

    seeds = '{32'hFFFF_FFFF, 32'h0000_0000, 32'($urandom), 32'h8000_0001, 32'($urandom)};
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      write_seed(seeds[ph]);
      no_gaps = (ph == 3);
      squeeze = (ph == 1);
      sent0 = beats_sent;
      while (beats_sent - sent0 < PHASE_BEATS) begin
        r = $urandom_range(0, 99);
        if (r < 60) len = $urandom_range(0, 20);
        else if (r < 90) len = $urandom_range(16, 48);
        else len = $urandom_range(49, 80);
        send_message(len, $urandom_range(0, 1));
      end
      in_tvalid <= 1'b0;
    end

    settle();
    if (sb.digest_q.size() != 0) begin
      $error("digest: %0d expected beats never arrived", sb.digest_q.size());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/xh32_pkg.sv
src/xh32_front.sv
src/xh32_back.sv
src/xxhash32_byte_stream_core.sv
tb/xxhash32_byte_stream_core_tb.sv
